// File: hw/rtl/throttle_brake_input_qualifier_macros.svh
// ----------------------------------------------------------------------------
// throttle_brake_input_qualifier assertion macros
// shared immediate-to-next and same-cycle property forms on clk_i / rst_ni
// ----------------------------------------------------------------------------
`ifndef THROTTLE_BRAKE_INPUT_QUALIFIER_MACROS_SVH
`define THROTTLE_BRAKE_INPUT_QUALIFIER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TBIQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TBIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tbiq_pkg.sv
// ----------------------------------------------------------------------------
// tbiq_pkg
// types and register indexes of the throttle and brake input qualifier
// ----------------------------------------------------------------------------
package tbiq_pkg;

  localparam int unsigned CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] REG_WINDOW_LOW     = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_WINDOW_HIGH    = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_THROTTLE_START = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_THROTTLE_END   = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_BRAKE_START    = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_BRAKE_END      = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_BRAKE_ENABLE   = 3'd6;
  localparam logic [CfgIdxBits-1:0] REG_SAFE_START     = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THR,
    ST_THR_WAIT,
    ST_BRK,
    ST_BRK_WAIT,
    ST_DONE
  } tbiq_state_e;

endpackage

// File: hw/rtl/throttle_brake_input_qualifier.sv
// ----------------------------------------------------------------------------
// throttle_brake_input_qualifier
// window check, linear level mapping and safe-start latch for throttle/brake
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser op, tdata sample
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata levels and flags
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  one transaction in, one out; power off and a fault need no division, while
//  a sample may need one for throttle, for brake or both, each run in turn on
//  the shared one-bit-per-cycle divider
//  s_axis_tready and cfg_ready_o are high only while idle; a waiting result
//  does not block input
//  asynchronous active-low reset loads register defaults, no clearing pass
// ----------------------------------------------------------------------------
module throttle_brake_input_qualifier
  import tbiq_pkg::*;
#(
  parameter int unsigned LEVEL_FRAC_BITS = 16,
  parameter int unsigned VOLT_BITS       = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op
  input  logic                             s_axis_tuser,
  // throttle_mv, throttle_valid, brake_mv, brake_valid
  input  logic [((2*VOLT_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // throttle_level, brake_level, wire_fault, read_error, held_throttle_mv,
  // held_brake_mv
  output logic [((2*LEVEL_FRAC_BITS+2*VOLT_BITS+4+7)/8)*8-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CfgIdxBits-1:0]            cfg_index_i,
  input  logic [VOLT_BITS-1:0]             cfg_data_i
);

  localparam int unsigned V       = VOLT_BITS;
  localparam int unsigned F       = LEVEL_FRAC_BITS;
  localparam int unsigned NumBits = V + F;
  localparam int unsigned OutW    = 2*(F+1) + 2 + 2*V;
  localparam int unsigned OutTdW  = ((OutW + 7) / 8) * 8;
  localparam int unsigned Thresh  = ((2**F) * 5 + 99) / 100;

  localparam logic [F:0] LevelFull  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] SafeThresh = (F+1)'(Thresh);

  // configuration registers
  logic [V-1:0] win_lo_q, win_hi_q, thr_start_q, thr_end_q, brk_start_q, brk_end_q;
  logic         brk_en_q;

  // persistent state
  logic         fault_q, unlocked_q;
  logic [V-1:0] thold_q, bhold_q;

  // captured transaction
  logic         op_q, tok_q, bok_q;
  logic [V-1:0] tv_q, bv_q;

  logic [F:0]   tlvl_q, blvl_q;

  // result register
  logic         out_valid_q, out_valid_d;
  logic [F:0]   out_tlvl_q, out_blvl_q;
  logic         out_fault_q, out_rderr_q;
  logic [V-1:0] out_thold_q, out_bhold_q;

  tbiq_state_e state_q, state_d;

  logic               div_start, div_done;
  logic [NumBits-1:0] div_numer, div_quot;
  logic [V-1:0]       div_denom;

  logic t_fault, t_need_div, b_use, b_need_div, commit;

  logic         c_fault, c_unlocked, c_rderr;
  logic [V-1:0] c_thold, c_bhold;
  logic [F:0]   c_tlvl, c_blvl;

  assign cfg_ready_o = (state_q == ST_IDLE);

  assign t_fault    = !tok_q || (tv_q < win_lo_q) || (tv_q > win_hi_q);
  assign t_need_div = (tv_q > thr_start_q) && (tv_q < thr_end_q);
  assign b_use      = brk_en_q && bok_q;
  assign b_need_div = b_use && (bv_q > brk_start_q) &&
                      ({1'b0, brk_end_q} > ({1'b0, brk_start_q} + (V+1)'(1)));
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_THR;
      end
      ST_THR: begin
        if (op_q || t_fault) state_d = ST_DONE;
        else if (t_need_div) state_d = ST_THR_WAIT;
        else                 state_d = ST_BRK;
      end
      ST_THR_WAIT: begin
        if (div_done) state_d = ST_BRK;
      end
      ST_BRK: begin
        state_d = b_need_div ? ST_BRK_WAIT : ST_DONE;
      end
      ST_BRK_WAIT: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_numer     = {brk_start_q, F'(0)};
    div_denom     = brk_end_q - brk_start_q;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_THR: begin
        div_start = !op_q && !t_fault && t_need_div;
        div_numer = {tv_q - thr_start_q, F'(0)};
        div_denom = thr_end_q - thr_start_q;
      end
      ST_BRK: begin
        div_start = b_need_div;
        div_numer = {bv_q - brk_start_q, F'(0)};
      end
      default: ;
    endcase
  end

  tbiq_divider #(
    .NumBits(NumBits),
    .DenBits(V)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(div_numer),
    .denom_i(div_denom),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // result of the current transaction
  always_comb begin
    c_fault    = fault_q;
    c_unlocked = unlocked_q;
    c_rderr    = 1'b0;
    c_thold    = thold_q;
    c_bhold    = bhold_q;
    c_tlvl     = '0;
    c_blvl     = '0;
    priority if (op_q) begin
      c_thold = '0;
      c_bhold = '0;
    end else if (t_fault) begin
      c_fault = 1'b1;
      c_rderr = !tok_q;
    end else begin
      c_fault = 1'b0;
      c_thold = tv_q;
      if (b_use) c_bhold = bv_q;
      c_tlvl = tlvl_q;
      c_blvl = blvl_q;
      if (!unlocked_q) begin
        if (tlvl_q < SafeThresh) begin
          c_unlocked = 1'b1;
        end else begin
          c_tlvl = '0;
          c_blvl = '0;
        end
      end
    end
  end

  assign out_valid_d = commit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      win_lo_q    <= V'(200);
      win_hi_q    <= V'(3200);
      thr_start_q <= V'(800);
      thr_end_q   <= V'(2600);
      brk_start_q <= '0;
      brk_end_q   <= '0;
      brk_en_q    <= 1'b0;
      fault_q     <= 1'b0;
      unlocked_q  <= 1'b1;
      thold_q     <= '0;
      bhold_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        fault_q    <= c_fault;
        unlocked_q <= c_unlocked;
        thold_q    <= c_thold;
        bhold_q    <= c_bhold;
      end else if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_WINDOW_LOW:     win_lo_q    <= cfg_data_i;
          REG_WINDOW_HIGH:    win_hi_q    <= cfg_data_i;
          REG_THROTTLE_START: thr_start_q <= cfg_data_i;
          REG_THROTTLE_END:   thr_end_q   <= cfg_data_i;
          REG_BRAKE_START:    brk_start_q <= cfg_data_i;
          REG_BRAKE_END:      brk_end_q   <= cfg_data_i;
          REG_BRAKE_ENABLE:   brk_en_q    <= cfg_data_i[0];
          REG_SAFE_START:     unlocked_q  <= !cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      tv_q  <= s_axis_tdata[V-1:0];
      tok_q <= s_axis_tdata[V];
      bv_q  <= s_axis_tdata[2*V:V+1];
      bok_q <= s_axis_tdata[2*V+1];
    end
    if (state_q == ST_THR) begin
      tlvl_q <= (tv_q <= thr_start_q) ? '0 : LevelFull;
      blvl_q <= '0;
    end
    if (state_q == ST_THR_WAIT && div_done) begin
      tlvl_q <= div_quot[F:0];
    end
    if (state_q == ST_BRK_WAIT && div_done) begin
      blvl_q <= (div_quot > NumBits'(LevelFull)) ? LevelFull : div_quot[F:0];
    end
    if (commit) begin
      out_tlvl_q  <= c_tlvl;
      out_blvl_q  <= c_blvl;
      out_fault_q <= c_fault;
      out_rderr_q <= c_rderr;
      out_thold_q <= c_thold;
      out_bhold_q <= c_bhold;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdW'({out_bhold_q, out_thold_q, out_rderr_q, out_fault_q,
                                  out_blvl_q, out_tlvl_q});

  `include "throttle_brake_input_qualifier_macros.svh"

  `TBIQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while busy")
  `TBIQ_ASSERT_SAME(a_fault_zero_levels, out_valid_q && out_fault_q, (out_tlvl_q == '0) && (out_blvl_q == '0), "levels not zero on fault")
  `TBIQ_ASSERT_SAME(a_rderr_implies_fault, out_valid_q && out_rderr_q, out_fault_q, "read error without fault")
  `TBIQ_ASSERT_SAME(a_level_in_range, out_valid_q, (out_tlvl_q <= LevelFull) && (out_blvl_q <= LevelFull), "level above full scale")

endmodule

// File: hw/rtl/tbiq_divider.sv
// ----------------------------------------------------------------------------
// tbiq_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tbiq_divider #(
  parameter int unsigned NumBits = 28,
  parameter int unsigned DenBits = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] numer_i,
  input  logic [DenBits-1:0] denom_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);
  localparam logic [CntBits-1:0] CntInit = CntBits'(NumBits);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits-1:0] rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [NumBits-1:0] quo_q, quo_d;

  logic [DenBits:0] trial;
  logic [DenBits:0] diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NumBits-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntInit;
      rem_d  = '0;
      den_d  = denom_i;
      quo_d  = numer_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DenBits-1:0] : trial[DenBits-1:0];
      quo_d = {quo_q[NumBits-2:0], ge};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: verif/tb_throttle_brake_input_qualifier.sv
// ----------------------------------------------------------------------------
// tb_throttle_brake_input_qualifier
// self-checking regression: a queue-fed driver sends samples and power-off
// transactions, a local predictor computes levels, flags and held voltages,
// and a monitor compares each output transaction field by field; several
// register settings are loaded between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_throttle_brake_input_qualifier;
  import tbiq_pkg::*;

  localparam logic [16:0] LevelFull    = 17'h10000;
  localparam int unsigned SafeThresh   = 3277;
  localparam int unsigned WatchdogMax  = 4000;
  localparam int unsigned SettleCycles = 80;

  typedef struct packed {
    logic        op;
    logic [11:0] throttle_mv;
    logic        throttle_valid;
    logic [11:0] brake_mv;
    logic        brake_valid;
  } sample_t;

  typedef struct packed {
    logic [16:0] throttle_level;
    logic [16:0] brake_level;
    logic        wire_fault;
    logic        read_error;
    logic [11:0] held_throttle_mv;
    logic [11:0] held_brake_mv;
  } levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  throttle_brake_input_qualifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic [11:0] cfg_win_lo = 12'd200;
  logic [11:0] cfg_win_hi = 12'd3200;
  logic [11:0] cfg_thr_start = 12'd800;
  logic [11:0] cfg_thr_end = 12'd2600;
  logic [11:0] cfg_brk_start = 12'd0;
  logic [11:0] cfg_brk_end = 12'd0;
  bit          cfg_brk_en = 1'b0;

  logic [16:0] thr_level_q = '0;
  logic [16:0] brk_level_q = '0;
  logic [11:0] thr_hold_q = '0;
  logic [11:0] brk_hold_q = '0;
  bit          fault_q = 1'b0;
  bit          unlocked_q = 1'b1;

  sample_t pending_samples[$];
  levels_t expected_levels[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_cnt = 0;
  bit          s_fire = 1'b0;
  bit          idle_on = 1'b1;

  function automatic logic [16:0] ramp_level(logic [11:0] v, logic [11:0] lo, logic [11:0] hi);
    int unsigned q;
    if (v <= lo) return '0;
    if (int'(hi) <= int'(lo) + 1) return '0;
    q = ((int'(v) - int'(lo)) << 16) / (int'(hi) - int'(lo));
    return (q > LevelFull) ? LevelFull : q[16:0];
  endfunction

  function automatic levels_t qualify(sample_t s);
    levels_t r;
    logic [16:0] t_lvl;
    logic [16:0] b_lvl;
    bit rd_err;
    rd_err = 1'b0;
    if (s.op) begin
      thr_level_q = '0;
      brk_level_q = '0;
      thr_hold_q = '0;
      brk_hold_q = '0;
    end else if (!s.throttle_valid || s.throttle_mv < cfg_win_lo ||
                 s.throttle_mv > cfg_win_hi) begin
      rd_err = !s.throttle_valid;
      fault_q = 1'b1;
      thr_level_q = '0;
      brk_level_q = '0;
    end else begin
      fault_q = 1'b0;
      thr_hold_q = s.throttle_mv;
      b_lvl = '0;
      if (s.throttle_mv <= cfg_thr_start) t_lvl = '0;
      else if (s.throttle_mv >= cfg_thr_end) t_lvl = LevelFull;
      else t_lvl = ramp_level(s.throttle_mv, cfg_thr_start, cfg_thr_end);
      if (cfg_brk_en && s.brake_valid) begin
        brk_hold_q = s.brake_mv;
        b_lvl = ramp_level(s.brake_mv, cfg_brk_start, cfg_brk_end);
      end
      if (!unlocked_q) begin
        if (t_lvl < SafeThresh) begin
          unlocked_q = 1'b1;
        end else begin
          t_lvl = '0;
          b_lvl = '0;
        end
      end
      thr_level_q = t_lvl;
      brk_level_q = b_lvl;
    end
    r.throttle_level   = fault_q ? '0 : thr_level_q;
    r.brake_level      = fault_q ? '0 : brk_level_q;
    r.wire_fault       = fault_q;
    r.read_error       = rd_err;
    r.held_throttle_mv = thr_hold_q;
    r.held_brake_mv    = brk_hold_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    sample_t s;
    bit nxt_valid;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid && !s_fire;
      s_fire = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0) begin
          s = pending_samples.pop_front();
          s_axis_tuser <= s.op;
          s_axis_tdata <= {6'b0, s.brake_valid, s.brake_mv, s.throttle_valid, s.throttle_mv};
          nxt_valid = 1'b1;
          send_gap = idle_on ? pick_gap() : 0;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    bit nxt_ready;
    if (rst_ni) begin
      nxt_ready = 1'b1;
      if (stall_cnt > 0) begin
        stall_cnt--;
        nxt_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        stall_cnt = pick_gap();
        nxt_ready = (stall_cnt == 0);
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // input capture and prediction
  always @(posedge clk_i) begin
    sample_t s;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      s.op             = s_axis_tuser;
      s.throttle_mv    = s_axis_tdata[11:0];
      s.throttle_valid = s_axis_tdata[12];
      s.brake_mv       = s_axis_tdata[24:13];
      s.brake_valid    = s_axis_tdata[25];
      expected_levels.push_back(qualify(s));
      s_fire = 1'b1;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_levels.size() == 0) begin
        $error("output transaction with no expected result: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        check_field("throttle_level", m_axis_tdata[16:0], want.throttle_level);
        check_field("brake_level", m_axis_tdata[33:17], want.brake_level);
        check_field("wire_fault", m_axis_tdata[34], want.wire_fault);
        check_field("read_error", m_axis_tdata[35], want.read_error);
        check_field("held_throttle_mv", m_axis_tdata[47:36], want.held_throttle_mv);
        check_field("held_brake_mv", m_axis_tdata[59:48], want.held_brake_mv);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogMax) begin
        $display("throttle_brake_input_qualifier regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WINDOW_LOW:     cfg_win_lo = val;
      REG_WINDOW_HIGH:    cfg_win_hi = val;
      REG_THROTTLE_START: cfg_thr_start = val;
      REG_THROTTLE_END:   cfg_thr_end = val;
      REG_BRAKE_START:    cfg_brk_start = val;
      REG_BRAKE_END:      cfg_brk_end = val;
      REG_BRAKE_ENABLE:   cfg_brk_en = val[0];
      REG_SAFE_START:     unlocked_q = !val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_flag(logic [2:0] idx, bit val);
    logic [10:0] junk;
    junk = 11'($urandom);
    write_reg(idx, {junk, val});
  endtask

  task automatic push_sample(bit op, int tv, bit tok, int bv, bit bok);
    sample_t s;
    s.op = op;
    s.throttle_mv = tv[11:0];
    s.throttle_valid = tok;
    s.brake_mv = bv[11:0];
    s.brake_valid = bok;
    pending_samples.push_back(s);
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int clamp_mv(int v);
    return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
  endfunction

  function automatic int pick_end(int st);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return st;
    if (r < 12) return clamp_mv(st + 1);
    if (r < 20) return $urandom_range(0, 4095);
    return clamp_mv(st + $urandom_range(100, 2500));
  endfunction

  task automatic load_settings(int k);
    int wl, wh, ts, te, bs, be;
    bit ben, sse;
    if (k == 0) begin
      wl = 0; wh = 0; ts = 0; te = 0; bs = 0; be = 0; ben = 1'b0; sse = 1'b0;
    end else if (k == 1) begin
      wl = 4095; wh = 4095; ts = 4095; te = 4095; bs = 4095; be = 4095;
      ben = 1'b1; sse = 1'b1;
    end else begin
      wl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
      wh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(2500, 4095);
      ts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1500);
      te = pick_end(ts);
      bs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1500);
      be = pick_end(bs);
      ben = ($urandom_range(0, 3) != 0);
      sse = 1'($urandom_range(0, 1));
    end
    write_reg(REG_WINDOW_LOW, wl[11:0]);
    write_reg(REG_WINDOW_HIGH, wh[11:0]);
    write_reg(REG_THROTTLE_START, ts[11:0]);
    write_reg(REG_THROTTLE_END, te[11:0]);
    write_reg(REG_BRAKE_START, bs[11:0]);
    write_reg(REG_BRAKE_END, be[11:0]);
    write_flag(REG_BRAKE_ENABLE, ben);
    write_flag(REG_SAFE_START, sse);
  endtask

  task automatic push_random_sample();
    int unsigned r;
    int tv, bv;
    bit op, tok, bok;
    op = ($urandom_range(0, 99) < 4);
    tok = ($urandom_range(0, 99) < 92);
    bok = ($urandom_range(0, 99) < 85);
    r = $urandom_range(0, 99);
    if (r < 60) begin
      tv = $urandom_range(cfg_win_lo, cfg_win_hi);
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0: tv = clamp_mv(int'(cfg_win_lo) - 1);
        1: tv = cfg_win_lo;
        2: tv = cfg_win_hi;
        default: tv = clamp_mv(int'(cfg_win_hi) + 1);
      endcase
    end else if (r < 85) begin
      tv = clamp_mv(int'(cfg_thr_start) + $urandom_range(0, 200) - 100);
    end else begin
      tv = $urandom_range(0, 4095);
    end
    if ($urandom_range(0, 1) == 0) bv = $urandom_range(cfg_brk_start, cfg_brk_end);
    else bv = $urandom_range(0, 4095);
    push_sample(op, tv, tok, bv, bok);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: window edges, read errors, power off
    push_sample(1, 4095, 1, 4095, 1);
    push_sample(0, 0, 0, 0, 0);
    push_sample(0, 199, 1, 0, 1);
    push_sample(0, 200, 1, 4095, 1);
    push_sample(0, 3200, 1, 0, 0);
    push_sample(0, 3201, 1, 0, 1);
    push_sample(0, 4095, 1, 4095, 1);
    push_sample(0, 1700, 1, 2000, 1);
    push_sample(0, 801, 1, 0, 0);
    push_sample(0, 2599, 1, 1234, 1);
    push_sample(0, 2000, 0, 3000, 1);
    push_sample(1, 0, 0, 0, 0);
    settle();

    // brake enabled, safe start armed
    write_reg(REG_WINDOW_LOW, 12'd0);
    write_reg(REG_WINDOW_HIGH, 12'd4095);
    write_reg(REG_THROTTLE_START, 12'd0);
    write_reg(REG_THROTTLE_END, 12'd4095);
    write_reg(REG_BRAKE_START, 12'd100);
    write_reg(REG_BRAKE_END, 12'd4000);
    write_flag(REG_BRAKE_ENABLE, 1'b1);
    write_flag(REG_SAFE_START, 1'b1);
    push_sample(0, 4095, 1, 4095, 1);
    push_sample(0, 100, 1, 2000, 1);
    push_sample(0, 4095, 1, 4095, 1);
    push_sample(0, 2000, 1, 50, 1);
    push_sample(0, 2000, 1, 3000, 0);
    push_sample(0, 0, 1, 0, 1);
    settle();

    // safe start threshold boundary
    write_reg(REG_THROTTLE_END, 12'd2000);
    write_flag(REG_SAFE_START, 1'b1);
    push_sample(0, 101, 1, 2000, 1);
    push_sample(0, 100, 1, 2000, 1);
    settle();

    // inverted throttle ramp, tiny and inverted brake spans
    write_reg(REG_THROTTLE_START, 12'd2000);
    write_reg(REG_THROTTLE_END, 12'd1000);
    write_reg(REG_BRAKE_START, 12'd1000);
    write_reg(REG_BRAKE_END, 12'd1001);
    write_flag(REG_SAFE_START, 1'b1);
    push_sample(0, 2000, 1, 1000, 1);
    push_sample(0, 2001, 1, 4095, 1);
    push_sample(0, 3000, 1, 1001, 1);
    settle();
    write_reg(REG_BRAKE_END, 12'd500);
    push_sample(0, 1500, 1, 3000, 1);
    settle();

    // random phases
    for (int k = 0; k < 8; k++) begin
      load_settings(k);
      for (int b = 0; b < 4; b++) begin
        idle_on = (b != 3);
        if (b != 0) write_flag(REG_SAFE_START, 1'($urandom_range(0, 1)));
        for (int n = 0; n < 62; n++) push_random_sample();
        settle();
      end
    end

    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("throttle_brake_input_qualifier regression: pass");
    end else begin
      $display("throttle_brake_input_qualifier regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tbiq_pkg.sv
hw/rtl/tbiq_divider.sv
hw/rtl/throttle_brake_input_qualifier.sv
verif/tb_throttle_brake_input_qualifier.sv
